// ----- src/esd_pkg.sv -----
// Shared types, character codes and helpers for the escape sequence decoder.
package esd_pkg;

    localparam int CHAR_W   = 21;
    localparam int CODE_W   = 32;
    localparam int USED_W   = 3;
    localparam int ACC_W    = 16;
    localparam int DIGIT_W  = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CODE_W-1:0] EPS_RESET = 32'hFFFF_FFFE;

    // Source character codes
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 21'h5C;
    localparam logic [CHAR_W-1:0] CH_A         = 21'h61;
    localparam logic [CHAR_W-1:0] CH_B         = 21'h62;
    localparam logic [CHAR_W-1:0] CH_E         = 21'h65;
    localparam logic [CHAR_W-1:0] CH_F         = 21'h66;
    localparam logic [CHAR_W-1:0] CH_N         = 21'h6E;
    localparam logic [CHAR_W-1:0] CH_R         = 21'h72;
    localparam logic [CHAR_W-1:0] CH_T         = 21'h74;
    localparam logic [CHAR_W-1:0] CH_U         = 21'h75;
    localparam logic [CHAR_W-1:0] CH_V         = 21'h76;
    localparam logic [CHAR_W-1:0] CH_X         = 21'h78;

    // Control character codes produced by simple escapes
    localparam logic [CODE_W-1:0] CC_BEL = 32'd7;
    localparam logic [CODE_W-1:0] CC_BS  = 32'd8;
    localparam logic [CODE_W-1:0] CC_HT  = 32'd9;
    localparam logic [CODE_W-1:0] CC_LF  = 32'd10;
    localparam logic [CODE_W-1:0] CC_VT  = 32'd11;
    localparam logic [CODE_W-1:0] CC_FF  = 32'd12;
    localparam logic [CODE_W-1:0] CC_CR  = 32'd13;

    // Digit counts for the two hex escapes
    localparam logic [DIGIT_W-1:0] X_DIGITS = 3'd2;
    localparam logic [DIGIT_W-1:0] U_DIGITS = 3'd4;

    // Register address bit that selects the register index
    localparam int REG_IDX_BIT = 2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_BAD_HEX = 2'd2
    } t_status;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] char_out;
        logic [USED_W-1:0] consumed;
        t_status           status;
    } t_result;

    // Returns {valid, value} for one hex digit character.
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        begin
            r = 5'b0;
            if (c >= 21'h30 && c <= 21'h39) begin
                r = {1'b1, c[3:0]};
            end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
                // a..f and A..F both have 1..6 in the low nibble
                r = {1'b1, 4'(c[3:0] + 4'd9)};
            end
            return r;
        end
    endfunction

endpackage

// ----- src/esd_ifs.sv -----
// Valid/ready stream interfaces for source characters and decoded results.
interface esd_in_if;
    logic                        valid;
    logic                        ready;
    logic [esd_pkg::CHAR_W-1:0]  char_in;
    logic                        last;

    modport source (output valid, output char_in, output last, input ready);
    modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface esd_out_if;
    logic                        valid;
    logic                        ready;
    logic [esd_pkg::CODE_W-1:0]  char_out;
    logic [esd_pkg::USED_W-1:0]  consumed;
    logic [1:0]                  status;

    modport source (output valid, output char_out, output consumed, output status, input ready);
    modport sink   (input valid, input char_out, input consumed, input status, output ready);
endinterface

// ----- src/esd_apb_regs.sv -----
// APB register block holding the epsilon code.
module esd_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esd_pkg::APB_AW-1:0]  paddr,
    input  logic [esd_pkg::APB_DW-1:0]  pwdata,
    output logic [esd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [esd_pkg::CODE_W-1:0]  o_epsilon
);
    import esd_pkg::*;

    logic [CODE_W-1:0] r_eps_code;
    logic              wr_en;

    // index 0 is the only register
    assign wr_en = psel && penable && pwrite && !paddr[REG_IDX_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps_code <= EPS_RESET;
        end else if (wr_en) begin
            r_eps_code <= pwdata;
        end
    end

    assign prdata    = paddr[REG_IDX_BIT] ? '0 : r_eps_code;
    assign pready    = 1'b1;
    assign o_epsilon = r_eps_code;

endmodule

// ----- src/esd_decode.sv -----
// Escape decoder state and single-step decode logic.
module esd_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [esd_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_last,
    input  logic [esd_pkg::CODE_W-1:0]  i_epsilon,
    output esd_pkg::t_result            o_res
);
    import esd_pkg::*;

    t_phase             r_phase,  n_phase;
    logic [DIGIT_W-1:0] r_digits, n_digits;
    logic [ACC_W-1:0]   r_accum,  n_accum;
    logic               r_err,    n_err;
    logic [USED_W-1:0]  r_len,    n_len;

    logic [4:0]         hex;
    logic [ACC_W-1:0]   acc_next;
    logic [USED_W-1:0]  len_next;
    logic [DIGIT_W-1:0] digits_next;
    logic               err_next;
    logic               is_xu;
    t_result            res;

    // digit step shared by both blocks
    always_comb begin
        hex         = hex_digit(i_char);
        acc_next    = {r_accum[ACC_W-5:0], hex[3:0]};
        len_next    = r_len + 3'd1;
        digits_next = r_digits - 3'd1;
        err_next    = r_err | ~hex[4];
        is_xu       = (i_char == CH_X) || (i_char == CH_U);
    end

    // result of this step
    always_comb begin
        res          = '0;
        res.status   = ST_OK;
        unique case (r_phase)
            PH_ESC: begin
                res.emit     = 1'b1;
                res.consumed = 3'd2;
                case (i_char) inside
                    CH_A:         res.char_out = CC_BEL;
                    CH_B:         res.char_out = CC_BS;
                    CH_E:         res.char_out = i_epsilon;
                    CH_F:         res.char_out = CC_FF;
                    CH_N:         res.char_out = CC_LF;
                    CH_R:         res.char_out = CC_CR;
                    CH_T:         res.char_out = CC_HT;
                    CH_V:         res.char_out = CC_VT;
                    CH_X, CH_U: begin
                        // hex escape opens; only ends here if string ends
                        res.emit   = i_last;
                        res.status = i_last ? ST_TRUNC : ST_OK;
                    end
                    default:      res.char_out = CODE_W'(i_char);
                endcase
            end
            PH_HEX: begin
                res.consumed = len_next;
                if (digits_next == '0) begin
                    res.emit     = 1'b1;
                    res.status   = err_next ? ST_BAD_HEX : ST_OK;
                    res.char_out = err_next ? '0 : CODE_W'(acc_next);
                end else if (i_last) begin
                    res.emit   = 1'b1;
                    res.status = ST_TRUNC;
                end
            end
            default: begin
                // idle
                res.consumed = 3'd1;
                if (i_char == CH_BACKSLASH) begin
                    res.emit   = i_last;
                    res.status = i_last ? ST_TRUNC : ST_OK;
                end else begin
                    res.emit     = 1'b1;
                    res.char_out = CODE_W'(i_char);
                end
            end
        endcase
    end

    // next state; any result returns to idle
    always_comb begin
        n_phase  = PH_IDLE;
        n_digits = '0;
        n_accum  = '0;
        n_err    = 1'b0;
        n_len    = '0;
        if (!res.emit) begin
            unique case (r_phase)
                PH_ESC: begin
                    if (is_xu) begin
                        n_phase  = PH_HEX;
                        n_digits = (i_char == CH_X) ? X_DIGITS : U_DIGITS;
                        n_len    = 3'd2;
                    end
                end
                PH_HEX: begin
                    n_phase  = PH_HEX;
                    n_digits = digits_next;
                    n_accum  = acc_next;
                    n_err    = err_next;
                    n_len    = len_next;
                end
                default: begin
                    n_phase = PH_ESC;
                    n_len   = 3'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_digits <= '0;
            r_accum  <= '0;
            r_err    <= 1'b0;
            r_len    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_digits <= n_digits;
            r_accum  <= n_accum;
            r_err    <= n_err;
            r_len    <= n_len;
        end
    end

    assign o_res = res;

endmodule

// ----- src/escape_sequence_decoder.sv -----
// Top level: input register, escape decode step, result register, APB config.
//
// Decodes backslash escapes in a stream of 21-bit characters at one character
// per clock while the output is not stalled. A character accepted on the input
// channel lands in the input register, is decoded there against the sequence
// state, and any result is loaded into the result register when the character
// moves on, so a result passes through the input register and then the result
// register. Characters that only extend an open escape give no result.
// The input is ready whenever the input register is empty or its character
// can move on: the result register is empty, is being taken, or the pending
// character makes no result; a stalled output holds at most one character in
// the input register. The epsilon code for backslash e is at APB address 0
// and must only be written while no character is in flight.
module escape_sequence_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    esd_in_if.sink                      i_in,
    esd_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esd_pkg::APB_AW-1:0]  paddr,
    input  logic [esd_pkg::APB_DW-1:0]  pwdata,
    output logic [esd_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import esd_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_char;
    logic [USED_W-1:0] r_out_used;
    t_status           r_out_status;
    logic [CODE_W-1:0] epsilon;
    t_result           res;
    logic              step;
    logic              in_xfer;

    esd_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_epsilon (epsilon)
    );

    esd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_char    (r_in_char),
        .i_last    (r_in_last),
        .i_epsilon (epsilon),
        .o_res     (res)
    );

    // pending character moves on when its result has a place to go
    assign step       = r_in_valid && (!r_out_valid || o_out.ready || !res.emit);
    assign i_in.ready = !r_in_valid || step;
    assign in_xfer    = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= i_in.char_in;
            r_in_last <= i_in.last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.emit) begin
            r_out_char   <= res.char_out;
            r_out_used   <= res.consumed;
            r_out_status <= res.status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_out_char;
    assign o_out.consumed = r_out_used;
    assign o_out.status   = r_out_status;

    // a failed sequence never carries a character
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != ST_OK) |-> (r_out_char == '0))
        else $error("nonzero char_out on failed sequence");

    // consumed count stays within one to six
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_used >= 3'd1) && (r_out_used <= 3'd6))
        else $error("consumed out of range");

    // a bad digit is only reported on a complete hex escape
    a_bad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_BAD_HEX) |->
            (r_out_used == 3'd4) || (r_out_used == 3'd6))
        else $error("bad hex status with wrong length");

    // a full result register that is not taken never gets overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(step && res.emit))
        else $error("result register overrun");

endmodule
